// ----- rtl/core/aimd_pkg.sv -----
// Shared types, constants and lookup tables for the AIMD bitrate controller.
// Depends on nothing; every other file in rtl/core imports it.

package aimd_pkg;

   localparam int RATE_W     = 27;
   localparam int RTT_W      = 16;
   localparam int TIME_W     = 32;
   localparam int PCT_W      = 7;
   localparam int RUN_W      = 8;
   localparam int FRAC_BITS  = 34;
   localparam int MUL_W      = 35;
   localparam int PROD_W     = 62;
   localparam int PCT_BASE   = 100;
   localparam int PCT_CODES  = 128;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam int NUM_REGS   = 8;

   typedef logic [RATE_W-1:0] rate_type;

   // Action codes carried with every result.
   localparam logic [1:0] ACT_HOLD = 2'd0;
   localparam logic [1:0] ACT_DOWN = 2'd1;
   localparam logic [1:0] ACT_UP   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_RTT_UPPER  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RTT_LOW    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DECREASE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_INCREASE   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COOLDOWN   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FLOOR      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CEILING    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_START_RATE = 3'd7;

   // Defaults that stand in for a register holding zero.
   localparam logic [RTT_W-1:0]  DEF_RTT_UPPER = 16'd150;
   localparam logic [RTT_W-1:0]  DEF_RTT_LOW   = 16'd50;
   localparam logic [PCT_W-1:0]  DEF_DECREASE  = 7'd70;
   localparam logic [PCT_W-1:0]  DEF_INCREASE  = 7'd5;
   localparam logic [RTT_W-1:0]  DEF_COOLDOWN  = 16'd1000;
   localparam rate_type          DEF_FLOOR     = 27'd100000;
   localparam rate_type          DEF_CEILING   = 27'd8000000;
   localparam rate_type          DEF_START     = 27'd0;
   localparam logic [PCT_W-1:0]  PCT_LIMIT     = 7'd100;

   // With the start rate at its reset value of zero, the rate after reset is the ceiling.
   localparam rate_type RESET_RATE = DEF_CEILING;

   typedef struct packed {
      logic                kind;
      logic [RTT_W-1:0]    rtt_sample;
      logic [TIME_W-1:0]   timestamp;
   } req_item_type;

   typedef struct packed {
      rate_type            bitrate;
      logic [1:0]          action;
   } rsp_item_type;

   // Register values after defaults and corrections, as the datapath uses them.
   typedef struct packed {
      logic [RTT_W-1:0]    rtt_upper;
      logic [RTT_W-1:0]    rtt_low;
      logic [MUL_W-1:0]    dec_mul;
      logic [MUL_W-1:0]    inc_mul;
      logic [RTT_W-1:0]    cooldown;
      rate_type            rate_floor;
      rate_type            rate_ceiling;
      rate_type            start_rate;
   } eff_cfg_type;

   // Scaled reciprocals: floor(x * p / 100) == (x * MUL_TAB[p]) >> FRAC_BITS for any
   // 27-bit x, since the rounding error of each entry stays below 2^-34 * 2^27 < 1/100.
   typedef logic [MUL_W-1:0] mul_tab_type [0:PCT_CODES-1];

   function automatic mul_tab_type build_mul_tab();
      mul_tab_type tab;
      for (int p = 0; p < PCT_CODES; p++) begin
         tab[p] = MUL_W'(((64'(p) << FRAC_BITS) + 64'(PCT_BASE - 1)) / 64'(PCT_BASE));
      end
      return tab;
   endfunction

   localparam mul_tab_type MUL_TAB = build_mul_tab();

endpackage

// ----- rtl/core/aimd_csr.sv -----
// Configuration register file with APB-style access, plus the registered set of
// effective values (defaults and corrections applied). Depends on aimd_pkg.

module aimd_csr
   import aimd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output eff_cfg_type           eff
);

   logic [RTT_W-1:0]     rtt_upper_ff, rtt_low_ff, cooldown_ff;
   logic [PCT_W-1:0]     decrease_ff, increase_ff;
   rate_type             floor_ff, ceiling_ff, start_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   logic [RTT_W-1:0]     high_v, low_v;
   logic [PCT_W-1:0]     dec_v, inc_v;
   rate_type             floor_v, ceil_v;
   eff_cfg_type          eff_in, eff_ff;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_upper_ff <= DEF_RTT_UPPER;
         rtt_low_ff   <= DEF_RTT_LOW;
         decrease_ff  <= DEF_DECREASE;
         increase_ff  <= DEF_INCREASE;
         cooldown_ff  <= DEF_COOLDOWN;
         floor_ff     <= DEF_FLOOR;
         ceiling_ff   <= DEF_CEILING;
         start_ff     <= DEF_START;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_RTT_UPPER:  rtt_upper_ff <= csr_pwdata[RTT_W-1:0];
            REG_RTT_LOW:    rtt_low_ff   <= csr_pwdata[RTT_W-1:0];
            REG_DECREASE:   decrease_ff  <= csr_pwdata[PCT_W-1:0];
            REG_INCREASE:   increase_ff  <= csr_pwdata[PCT_W-1:0];
            REG_COOLDOWN:   cooldown_ff  <= csr_pwdata[RTT_W-1:0];
            REG_FLOOR:      floor_ff     <= csr_pwdata[RATE_W-1:0];
            REG_CEILING:    ceiling_ff   <= csr_pwdata[RATE_W-1:0];
            REG_START_RATE: start_ff     <= csr_pwdata[RATE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RTT_UPPER:  csr_prdata = CSR_DATA_W'(rtt_upper_ff);
         REG_RTT_LOW:    csr_prdata = CSR_DATA_W'(rtt_low_ff);
         REG_DECREASE:   csr_prdata = CSR_DATA_W'(decrease_ff);
         REG_INCREASE:   csr_prdata = CSR_DATA_W'(increase_ff);
         REG_COOLDOWN:   csr_prdata = CSR_DATA_W'(cooldown_ff);
         REG_FLOOR:      csr_prdata = CSR_DATA_W'(floor_ff);
         REG_CEILING:    csr_prdata = CSR_DATA_W'(ceiling_ff);
         REG_START_RATE: csr_prdata = CSR_DATA_W'(start_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Defaults and corrections, registered to keep them out of the per-item path.
   // The user writes the port only while the block is idle; it is not enforced.
   always_comb begin
      high_v  = (rtt_upper_ff != '0) ? rtt_upper_ff : DEF_RTT_UPPER;
      low_v   = (rtt_low_ff  != '0) ? rtt_low_ff  : DEF_RTT_LOW;
      dec_v   = (decrease_ff != '0) ? decrease_ff : DEF_DECREASE;
      inc_v   = (increase_ff != '0) ? increase_ff : DEF_INCREASE;
      floor_v = (floor_ff    != '0) ? floor_ff    : DEF_FLOOR;
      ceil_v  = (ceiling_ff  != '0) ? ceiling_ff  : DEF_CEILING;
      if (low_v >= high_v) begin
         low_v = high_v >> 1;
      end
      if (dec_v >= PCT_LIMIT) begin
         dec_v = DEF_DECREASE;
      end
      if (floor_v >= ceil_v) begin
         floor_v = ceil_v >> 1;
      end

      eff_in.rtt_upper    = high_v;
      eff_in.rtt_low      = low_v;
      eff_in.dec_mul      = MUL_TAB[dec_v];
      eff_in.inc_mul      = MUL_TAB[inc_v];
      eff_in.cooldown     = (cooldown_ff != '0) ? cooldown_ff : DEF_COOLDOWN;
      eff_in.rate_floor   = floor_v;
      eff_in.rate_ceiling = ceil_v;
      if (start_ff == '0) begin
         eff_in.start_rate = ceil_v;
      end else if (start_ff < floor_v) begin
         eff_in.start_rate = floor_v;
      end else if (start_ff > ceil_v) begin
         eff_in.start_rate = ceil_v;
      end else begin
         eff_in.start_rate = start_ff;
      end
   end

   always_ff @(posedge clock) begin
      eff_ff <= eff_in;
   end

   assign eff = eff_ff;

endmodule

// ----- rtl/core/aimd_update.sv -----
// Controller state (current rate, time of last change, low-RTT run) and the
// single-pass update that turns one item into one result. Depends on aimd_pkg.

module aimd_update
   import aimd_pkg::*;
#(
   parameter int INCREASE_RUN = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  eff_cfg_type  eff,
   output rsp_item_type result
);

   rate_type            rate_ff, rate_in;
   logic [TIME_W-1:0]   change_ff, change_in;
   logic [RUN_W-1:0]    run_ff, run_in;

   logic [PROD_W-1:0]   prod_dec, prod_inc;
   rate_type            nb_dec, dec_rate, headroom, up_rate;
   logic [RATE_W:0]     step;
   logic [RATE_W+1:0]   sum;
   logic [TIME_W-1:0]   elapsed;
   logic [RUN_W-1:0]    run_sat;
   logic [1:0]          act;

   always_comb begin
      // Decrease candidate: floor(rate * dec / 100), clamped.
      prod_dec = PROD_W'(rate_ff) * PROD_W'(eff.dec_mul);
      nb_dec   = prod_dec[FRAC_BITS +: RATE_W];
      if (nb_dec < eff.rate_floor) begin
         dec_rate = eff.rate_floor;
      end else if (nb_dec > eff.rate_ceiling) begin
         dec_rate = eff.rate_ceiling;
      end else begin
         dec_rate = nb_dec;
      end

      // Increase candidate: at least one unit of headroom * inc / 100.
      headroom = eff.rate_ceiling - rate_ff;
      prod_inc = PROD_W'(headroom) * PROD_W'(eff.inc_mul);
      step     = prod_inc[FRAC_BITS +: RATE_W+1];
      if (step == '0) begin
         step = (RATE_W+1)'(1);
      end
      sum = (RATE_W+2)'(rate_ff) + (RATE_W+2)'(step);
      if (sum > (RATE_W+2)'(eff.rate_ceiling)) begin
         up_rate = eff.rate_ceiling;
      end else begin
         up_rate = sum[RATE_W-1:0];
      end
      if (up_rate < eff.rate_floor) begin
         up_rate = eff.rate_floor;
      end

      elapsed = item.timestamp - change_ff;
      run_sat = (run_ff == '1) ? run_ff : run_ff + RUN_W'(1);

      rate_in   = rate_ff;
      change_in = change_ff;
      run_in    = run_ff;
      act       = ACT_HOLD;

      if (item.kind) begin
         rate_in   = eff.start_rate;
         change_in = '0;
         run_in    = '0;
      end else if (item.rtt_sample > eff.rtt_upper) begin
         run_in = '0;
         if (dec_rate < rate_ff) begin
            rate_in   = dec_rate;
            change_in = item.timestamp;
            act       = ACT_DOWN;
         end
      end else if (item.rtt_sample < eff.rtt_low) begin
         run_in = run_sat;
         if (run_sat >= RUN_W'(INCREASE_RUN) &&
             elapsed >= TIME_W'(eff.cooldown) &&
             rate_ff < eff.rate_ceiling) begin
            rate_in   = up_rate;
            change_in = item.timestamp;
            run_in    = '0;
            act       = ACT_UP;
         end
      end else begin
         run_in = '0;
      end

      result.bitrate = rate_in;
      result.action  = act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RESET_RATE;
         change_ff <= '0;
         run_ff    <= '0;
      end else if (fire) begin
         rate_ff   <= rate_in;
         change_ff <= change_in;
         run_ff    <= run_in;
      end
   end

   a_restart_loads: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind |=>
         rate_ff == $past(eff.start_rate) && change_ff == '0 && run_ff == '0)
      else $error("restart did not reload the controller state");

   a_down_lowers: assert property (@(posedge clock) disable iff (reset)
      fire && result.action == ACT_DOWN |=> rate_ff < $past(rate_ff))
      else $error("decrease did not lower the rate");

   a_up_raises: assert property (@(posedge clock) disable iff (reset)
      fire && result.action == ACT_UP |=> rate_ff > $past(rate_ff))
      else $error("increase did not raise the rate");

   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      fire && !item.kind && result.action == ACT_HOLD |=> rate_ff == $past(rate_ff))
      else $error("rate changed on a hold");

endmodule

// ----- rtl/core/aimd_bitrate_controller.sv -----
// Top level of the AIMD bitrate controller: stream ports, input and result
// registers, and the configuration port. Depends on aimd_pkg, aimd_csr, aimd_update.

// The controller takes one beat per cycle while rsp_tready stays high: each beat
// is an averaged RTT sample with a millisecond timestamp, or a restart (req_tuser
// high), and it returns exactly one result beat carrying the bitrate in effect
// afterwards and the action taken (hold, decrease or increase). A beat waits in
// the input register until the result register is free, then moves into the
// result register, from which its result is offered; the sustained rate is one
// beat per clock under the same condition. That rate is set by the rate update
// itself: the new rate of one beat is the starting point of the next, so the
// whole update (two 27 by 35 bit multiplies by scaled reciprocals of the
// percentages, clamps and the cooldown compare) is combinational between the
// two registers. While a result waits on the response side, the request side
// accepts a beat only into an empty input register. Configuration registers
// sit on an APB-style port at byte address 4*index and take effect on beats
// accepted after the write cycle; zero in a register selects its default, and
// inconsistent values are corrected. After reset the rate is the default ceiling.

module aimd_bitrate_controller
   import aimd_pkg::*;
#(
   parameter int INCREASE_RUN = 3
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,    // [15:0] rtt_sample, [47:16] timestamp
   input  logic                  req_tuser,    // [0] kind: 0 RTT sample, 1 restart

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,    // [26:0] bitrate, [28:27] action, [31:29] zero

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   eff_cfg_type   eff;

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   rsp_item_type  result;
   logic          advance;
   logic          req_fire;

   aimd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff         (eff)
   );

   // The beat in the input register moves on whenever the result register is
   // empty or is being emptied in this cycle; the state updates on that move.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind       <= req_tuser;
         in_item_ff.rtt_sample <= req_tdata[RTT_W-1:0];
         in_item_ff.timestamp  <= req_tdata[RTT_W +: TIME_W];
      end
   end

   aimd_update #(
      .INCREASE_RUN (INCREASE_RUN)
   ) u_update (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .eff    (eff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_item_ff.action, out_item_ff.bitrate};

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled beat lost from the input register");

   a_result_drained: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_tready && !advance |=> !out_valid_ff)
      else $error("result register shows a beat twice");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("request side stalled with an empty input register");

endmodule
